@@ hdl/vrt_pkg.sv @@
// Shared types, constants and helpers for the voxel ray traversal block.
`timescale 1ns / 1ps
package vrt_pkg;

  localparam int ResultCap = 64;
  localparam int CoordBits = 16;
  localparam int CntW      = $clog2(ResultCap + 1);
  localparam int MulAW     = 34;
  localparam int MulBW     = 32;
  localparam int MulPW     = MulAW + MulBW;

  localparam logic signed [31:0] TInf = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] TMin = 32'sh8000_0000;

  localparam logic [2:0] FaceOrigin = 3'd0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TMUL,
    S_TWR,
    S_EWR,
    S_ORIG,
    S_OUT,
    S_PICK,
    S_TM,
    S_S1,
    S_S2
  } state_e;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [31:0]          time_t;

  // Product shifted right by 16 with floor, saturated to 32 bits.
  function automatic time_t sat_shr16(input logic signed [MulPW-1:0] p);
    logic signed [MulPW-17:0] v;
    v = p[MulPW-1:16];
    if (!v[MulPW-17] && (v[MulPW-17:31] != '0)) return TInf;
    if (v[MulPW-17] && (v[MulPW-17:31] != '1)) return TMin;
    return v[31:0];
  endfunction

  function automatic time_t tadd(input time_t a, input time_t b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (a == TInf || b == TInf) return TInf;
    if (s > 33'sh0_7FFF_FFFF) return TInf;
    if (s < -33'sh0_8000_0000) return TMin;
    return s[31:0];
  endfunction

  function automatic logic [1:0] other_lo(input logic [1:0] ax);
    return (ax == 2'd0) ? 2'd1 : 2'd0;
  endfunction

  function automatic logic [1:0] other_hi(input logic [1:0] ax);
    return (ax == 2'd2) ? 2'd1 : 2'd2;
  endfunction

endpackage

@@ hdl/voxel_ray_traversal.sv @@
// Top level: voxel ray traversal sequencer around one shared multiplier.
//
//  port group   dir  handshake                 payload
//  cfg          in   cfg_valid_i / cfg_ready_o  max_range_i
//  in (ray)     in   in_valid_i / in_ready_o    origin_cell/frac, dir, inv_dir x/y/z
//  out (cell)   out  out_valid_o / out_ready_i  cell, entry_face, hit point, last_cell
//
// One multiplier does all the work. Setup runs S_TMUL, S_TWR and S_EWR
// per axis (first crossing time, then end cell), then S_ORIG for the
// origin word. Each further cell runs S_PICK, S_TM, S_S1 and S_S2 (pick
// axis, crossing time, two other axes), then S_OUT for the output word.
// A ray gives up to 64 cells. in_ready_o is high only while idle.
// Reset clears control state and sets max_range to 1280 (five cells).
// Output stalls hold the sequencer in place with the word unchanged.
`timescale 1ns / 1ps
module voxel_ray_traversal (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] max_range_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [15:0] origin_cell_x_i,
  input  logic signed [15:0] origin_cell_y_i,
  input  logic signed [15:0] origin_cell_z_i,
  input  logic [15:0] origin_frac_x_i,
  input  logic [15:0] origin_frac_y_i,
  input  logic [15:0] origin_frac_z_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  input  logic signed [31:0] inv_dir_x_i,
  input  logic signed [31:0] inv_dir_y_i,
  input  logic signed [31:0] inv_dir_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] cell_x_o,
  output logic signed [15:0] cell_y_o,
  output logic signed [15:0] cell_z_o,
  output logic [2:0]  entry_face_o,
  output logic signed [15:0] hit_cell_x_o,
  output logic signed [15:0] hit_cell_y_o,
  output logic signed [15:0] hit_cell_z_o,
  output logic [15:0] hit_frac_x_o,
  output logic [15:0] hit_frac_y_o,
  output logic [15:0] hit_frac_z_o,
  output logic        last_cell_o
);
  import vrt_pkg::*;

  // Control state.
  state_e          state_q, state_d;
  logic [1:0]      ax_q, ax_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [12:0]     range_q;

  // Per-ray state.
  coord_t      cur_q [3];
  coord_t      cur_d [3];
  coord_t      end_q [3];
  coord_t      end_d [3];
  time_t       t_q   [3];
  time_t       t_d   [3];
  time_t       iv_q  [3];
  logic        pos_q [3];
  logic        neg_q [3];
  coord_t      oc_q  [3];
  logic [15:0] of_q  [3];
  logic signed [15:0] dir_q [3];
  time_t       inv_q [3];

  // Result word.
  coord_t      hc_q [3];
  coord_t      hc_d [3];
  logic [15:0] hf_q [3];
  logic [15:0] hf_d [3];
  logic [2:0]  face_q, face_d;
  logic        last_q, last_d;
  time_t       tm_q, tm_d;

  // Shared multiplier.
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;

  vrt_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  logic in_fire;
  logic signed [15:0] in_oc  [3];
  logic [15:0]        in_of  [3];
  logic signed [15:0] in_dir [3];
  time_t              in_inv [3];

  assign in_oc  = '{origin_cell_x_i, origin_cell_y_i, origin_cell_z_i};
  assign in_of  = '{origin_frac_x_i, origin_frac_y_i, origin_frac_z_i};
  assign in_dir = '{dir_x_i, dir_y_i, dir_z_i};
  assign in_inv = '{inv_dir_x_i, inv_dir_y_i, inv_dir_z_i};

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_OUT);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= 13'd1280;
    end else if (cfg_valid_i) begin
      range_q <= max_range_i;
    end
  end

  // Ray registers: capture on accept, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < 3; i++) begin
        oc_q[i]  <= in_oc[i];
        of_q[i]  <= in_of[i];
        dir_q[i] <= in_dir[i];
        inv_q[i] <= in_inv[i];
        pos_q[i] <= (in_dir[i] > 16'sd0);
        neg_q[i] <= in_dir[i][15];
        if (in_dir[i] == 16'sd0) begin
          iv_q[i] <= TInf;
        end else if (!in_dir[i][15]) begin
          iv_q[i] <= in_inv[i];
        end else begin
          iv_q[i] <= (in_inv[i] == TMin) ? TInf : -in_inv[i];
        end
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      cur_q[i] <= cur_d[i];
      end_q[i] <= end_d[i];
      t_q[i]   <= t_d[i];
      hc_q[i]  <= hc_d[i];
      hf_q[i]  <= hf_d[i];
    end
    face_q <= face_d;
    last_q <= last_d;
    tm_q   <= tm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ax_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
      cnt_q   <= cnt_d;
    end
  end

  logic        at_end;
  logic [1:0]  pick;
  logic [1:0]  b1, b2;
  coord_t      pa;
  coord_t      diff;
  coord_t      diffc;
  logic [31:0] pos32;
  logic [31:0] s32;

  assign at_end = (cur_q[0] == end_q[0]) && (cur_q[1] == end_q[1]) &&
                  (cur_q[2] == end_q[2]);
  assign b1 = other_lo(ax_q);
  assign b2 = other_hi(ax_q);

  always_comb begin
    if (t_q[2] < t_q[1]) begin
      pick = (t_q[0] < t_q[2]) ? 2'd0 : 2'd2;
    end else begin
      pick = (t_q[0] < t_q[1]) ? 2'd0 : 2'd1;
    end
  end

  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    end_d   = end_q;
    t_d     = t_q;
    hc_d    = hc_q;
    hf_d    = hf_q;
    face_d  = face_q;
    last_d  = last_q;
    tm_d    = tm_q;
    mul_a   = '0;
    mul_b   = '0;
    pa      = '0;
    diff    = '0;
    diffc   = '0;
    pos32   = '0;
    s32     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cur_d   = in_oc;
          ax_d    = '0;
          state_d = S_TMUL;
        end
      end

      // Issue the first crossing time product for this axis.
      S_TMUL: begin
        mul_a = pos_q[ax_q] ? MulAW'(18'sd65536 - $signed({2'b0, of_q[ax_q]}))
                            : -MulAW'($signed({2'b0, of_q[ax_q]}));
        mul_b = inv_q[ax_q];
        state_d = S_TWR;
      end

      // Take the crossing time, issue direction times range.
      S_TWR: begin
        t_d[ax_q] = (pos_q[ax_q] || neg_q[ax_q]) ? sat_shr16(mul_p) : TInf;
        mul_a = MulAW'(dir_q[ax_q]);
        mul_b = MulBW'($signed({1'b0, range_q}));
        state_d = S_EWR;
      end

      // End cell: floor of origin plus the scaled direction.
      S_EWR: begin
        pos32 = {oc_q[ax_q], of_q[ax_q]} + 32'(mul_p[37:6]);
        end_d[ax_q] = pos32[31:16];
        if (ax_q == 2'd2) begin
          state_d = S_ORIG;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = S_TMUL;
        end
      end

      S_ORIG: begin
        hc_d    = oc_q;
        hf_d    = of_q;
        face_d  = FaceOrigin;
        last_d  = at_end;
        cnt_d   = CntW'(1);
        state_d = S_OUT;
      end

      S_OUT: begin
        if (out_ready_i) begin
          state_d = last_q ? S_IDLE : S_PICK;
        end
      end

      // Advance the winning axis and issue the crossing time product.
      S_PICK: begin
        ax_d = pick;
        if (pos_q[pick]) begin
          cur_d[pick] = cur_q[pick] + 16'sd1;
          face_d = {pick, 1'b0} + 3'd1;
          pa     = cur_q[pick] + 16'sd1;
        end else if (neg_q[pick]) begin
          cur_d[pick] = cur_q[pick] - 16'sd1;
          face_d = {pick, 1'b0} + 3'd2;
          pa     = cur_q[pick];
        end else begin
          face_d = FaceOrigin;
          pa     = cur_q[pick];
        end
        t_d[pick]  = tadd(t_q[pick], iv_q[pick]);
        hc_d[pick] = pa;
        hf_d[pick] = '0;
        diff  = pa - oc_q[pick];
        diffc = (diff == 16'sh8000) ? 16'sh8001 : diff;
        mul_a = $signed({diffc[15], diffc[15], diffc, 16'h0000}) -
                $signed({18'b0, of_q[pick]});
        mul_b = inv_q[pick];
        state_d = S_TM;
      end

      S_TM: begin
        tm_d    = sat_shr16(mul_p);
        mul_a   = MulAW'(tm_d);
        mul_b   = MulBW'(dir_q[b1]);
        state_d = S_S1;
      end

      S_S1: begin
        s32 = 32'(of_q[b1]) + 32'(mul_p[45:14]);
        hc_d[b1] = oc_q[b1] + $signed(s32[31:16]);
        hf_d[b1] = s32[15:0];
        mul_a   = MulAW'(tm_q);
        mul_b   = MulBW'(dir_q[b2]);
        state_d = S_S2;
      end

      S_S2: begin
        s32 = 32'(of_q[b2]) + 32'(mul_p[45:14]);
        hc_d[b2] = oc_q[b2] + $signed(s32[31:16]);
        hf_d[b2] = s32[15:0];
        last_d  = at_end || ((cnt_q + CntW'(1)) >= CntW'(ResultCap));
        cnt_d   = cnt_q + CntW'(1);
        state_d = S_OUT;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cell_x_o     = cur_q[0];
  assign cell_y_o     = cur_q[1];
  assign cell_z_o     = cur_q[2];
  assign entry_face_o = face_q;
  assign hit_cell_x_o = hc_q[0];
  assign hit_cell_y_o = hc_q[1];
  assign hit_cell_z_o = hc_q[2];
  assign hit_frac_x_o = hf_q[0];
  assign hit_frac_y_o = hf_q[1];
  assign hit_frac_z_o = hf_q[2];
  assign last_cell_o  = last_q;

endmodule

@@ hdl/vrt_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module vrt_mul (
  input  logic                              clk_i,
  input  logic signed [vrt_pkg::MulAW-1:0]  a_i,
  input  logic signed [vrt_pkg::MulBW-1:0]  b_i,
  output logic signed [vrt_pkg::MulPW-1:0]  p_o
);
  import vrt_pkg::*;

  logic signed [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the voxel ray traversal block.
`timescale 1ns / 1ps
module tb;
  import vrt_pkg::*;

  localparam int HoldOff  = 400;
  localparam int DogLimit = 20000;

  // Face codes as the block reports them.
  localparam logic [2:0] FaceNone = FaceOrigin;
  localparam logic [2:0] FaceXPos = 3'd1;
  localparam logic [2:0] FaceXNeg = 3'd2;
  localparam logic [2:0] FaceYPos = 3'd3;
  localparam logic [2:0] FaceYNeg = 3'd4;
  localparam logic [2:0] FaceZPos = 3'd5;
  localparam logic [2:0] FaceZNeg = 3'd6;

  typedef struct {
    logic [15:0] oc[3];
    logic [15:0] of[3];
    logic [15:0] d[3];
    logic [31:0] inv[3];
  } ray_t;

  typedef struct packed {
    logic [2:0][15:0] vox;
    logic [2:0]       face;
    logic [2:0][15:0] hc;
    logic [2:0][15:0] hf;
    logic             last;
  } cell_word_t;

  // Predicts the cells each ray visits and checks them in order.
  class cell_scoreboard;
    cell_word_t  cells_q[$];
    int          errors;
    logic [12:0] range_q88;

    function new();
      errors    = 0;
      range_q88 = 13'd1280;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint sx16(longint v);
      logic [15:0] w;
      w = v[15:0];
      return longint'($signed(w));
    endfunction

    function void note_ray(ray_t r);
      longint     c[3], f[3], d[3], inv[3], t[3], iv[3], hc[3], hf[3];
      int         sg[3];
      logic [15:0] cur[3], endc[3];
      logic [2:0] pos_face[3], neg_face[3];
      cell_word_t w;
      longint     pa, diff, tm, s;
      int         n, ax;
      pos_face = '{FaceXPos, FaceYPos, FaceZPos};
      neg_face = '{FaceXNeg, FaceYNeg, FaceZNeg};
      for (int a = 0; a < 3; a++) begin
        c[a]   = longint'($signed(r.oc[a]));
        f[a]   = longint'(r.of[a]);
        d[a]   = longint'($signed(r.d[a]));
        inv[a] = longint'($signed(r.inv[a]));
        cur[a] = r.oc[a];
        if (d[a] == 0) begin
          sg[a] = 0; t[a] = 64'sd2147483647; iv[a] = 64'sd2147483647;
        end else if (d[a] > 0) begin
          sg[a] = 1; t[a] = sat32(((65536 - f[a]) * inv[a]) >>> 16); iv[a] = inv[a];
        end else begin
          sg[a] = -1; t[a] = sat32(((-f[a]) * inv[a]) >>> 16); iv[a] = sat32(-inv[a]);
        end
        s       = (c[a] * 65536 + f[a] + ((d[a] * longint'(range_q88)) >>> 6)) >>> 16;
        endc[a] = s[15:0];
        hc[a]   = c[a];
        hf[a]   = f[a];
      end
      n = 0;
      forever begin
        for (int a = 0; a < 3; a++) begin
          w.vox[a] = cur[a];
          w.hc[a]  = hc[a][15:0];
          w.hf[a]  = hf[a][15:0];
        end
        w.last = (cur == endc) || (n + 1 >= ResultCap);
        if (n == 0) w.face = FaceNone;
        cells_q.push_back(w);
        n++;
        if (w.last) break;
        // Advance the axis with the earliest crossing; ties go to y, then z.
        if (t[2] < t[1]) ax = (t[0] < t[2]) ? 0 : 2;
        else ax = (t[0] < t[1]) ? 0 : 1;
        cur[ax] = cur[ax] + 16'(sg[ax]);
        t[ax]   = (t[ax] == 64'sd2147483647 || iv[ax] == 64'sd2147483647) ?
                  64'sd2147483647 : sat32(t[ax] + iv[ax]);
        w.face  = (sg[ax] > 0) ? pos_face[ax] : ((sg[ax] < 0) ? neg_face[ax] : FaceNone);
        pa   = sx16(longint'(cur[ax])) + ((sg[ax] < 0) ? 1 : 0);
        diff = sx16(pa - c[ax]);
        if (diff > 32767) diff = 32767;
        if (diff < -32767) diff = -32767;
        tm = sat32(((diff * 65536 - f[ax]) * inv[ax]) >>> 16);
        hc[ax] = pa;
        hf[ax] = 0;
        for (int b = 0; b < 3; b++) begin
          if (b != ax) begin
            s     = f[b] + ((tm * d[b]) >>> 14);
            hc[b] = c[b] + (s >>> 16);
            hf[b] = s - ((s >>> 16) * 65536);
          end
        end
      end
    endfunction

    function void check_cell(cell_word_t act);
      cell_word_t exp_w;
      if (cells_q.size() == 0) begin
        $display("%0t: unexpected cell word %h", $time, act);
        errors++;
        return;
      end
      exp_w = cells_q.pop_front();
      for (int a = 0; a < 3; a++) begin
        if (act.vox[a] !== exp_w.vox[a]) begin
          $display("%0t: cell[%0d] exp %h got %h", $time, a, exp_w.vox[a], act.vox[a]);
          errors++;
        end
        if (act.hc[a] !== exp_w.hc[a]) begin
          $display("%0t: hit_cell[%0d] exp %h got %h", $time, a, exp_w.hc[a], act.hc[a]);
          errors++;
        end
        if (act.hf[a] !== exp_w.hf[a]) begin
          $display("%0t: hit_frac[%0d] exp %h got %h", $time, a, exp_w.hf[a], act.hf[a]);
          errors++;
        end
      end
      if (act.face !== exp_w.face) begin
        $display("%0t: entry_face exp %0d got %0d", $time, exp_w.face, act.face);
        errors++;
      end
      if (act.last !== exp_w.last) begin
        $display("%0t: last_cell exp %b got %b", $time, exp_w.last, act.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] max_range = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] oc_x = '0, oc_y = '0, oc_z = '0, of_x = '0, of_y = '0, of_z = '0;
  logic [15:0] d_x = '0, d_y = '0, d_z = '0;
  logic [31:0] inv_x = '0, inv_y = '0, inv_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] cx, cy, cz, hcx, hcy, hcz, hfx, hfy, hfz;
  logic [2:0]  face;
  logic        last;

  cell_scoreboard sb = new();
  bit calm = 0;       // no idling on either side
  bit hold_req = 0;   // ask the receiver for one long stall
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  voxel_ray_traversal DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .max_range_i(max_range),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .origin_cell_x_i(oc_x), .origin_cell_y_i(oc_y), .origin_cell_z_i(oc_z),
    .origin_frac_x_i(of_x), .origin_frac_y_i(of_y), .origin_frac_z_i(of_z),
    .dir_x_i(d_x), .dir_y_i(d_y), .dir_z_i(d_z),
    .inv_dir_x_i(inv_x), .inv_dir_y_i(inv_y), .inv_dir_z_i(inv_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .cell_x_o(cx), .cell_y_o(cy), .cell_z_o(cz), .entry_face_o(face),
    .hit_cell_x_o(hcx), .hit_cell_y_o(hcy), .hit_cell_z_o(hcz),
    .hit_frac_x_o(hfx), .hit_frac_y_o(hfy), .hit_frac_z_o(hfz),
    .last_cell_o(last)
  );

  // Check every cell word as it leaves the block.
  always @(posedge clk) begin
    cell_word_t w;
    if (rst_n && out_valid && out_ready) begin
      w.vox  = {cz, cy, cx};
      w.face = face;
      w.hc   = {hcz, hcy, hcx};
      w.hf   = {hfz, hfy, hfx};
      w.last = last;
      sb.check_cell(w);
    end
  end

  // Watchdog: end the run if no word moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= DogLimit) begin
      $display("[voxel_ray_traversal] ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldOff) @(posedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Offer one ray; start and end on a rising edge.
  task automatic send_ray(ray_t r);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    oc_x <= r.oc[0]; oc_y <= r.oc[1]; oc_z <= r.oc[2];
    of_x <= r.of[0]; of_y <= r.of[1]; of_z <= r.of[2];
    d_x <= r.d[0]; d_y <= r.d[1]; d_z <= r.d[2];
    inv_x <= r.inv[0]; inv_y <= r.inv[1]; inv_z <= r.inv[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_ray(r);
  endtask

  // Wait for the walk in flight to drain, then write the range register.
  task automatic write_range(logic [12:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.cells_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    max_range <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.range_q88 = v;
  endtask

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'sd16384;
      2:       return -16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // Well-formed ray: inverse matches direction; sometimes garbage inverses.
  function automatic ray_t rand_ray(bit noisy);
    ray_t r;
    for (int a = 0; a < 3; a++) begin
      r.oc[a] = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 64)) - 32);
      r.of[a] = 16'($urandom);
      r.d[a]  = rand_dir();
      if (noisy || r.d[a] == 0)
        r.inv[a] = $urandom;
      else
        r.inv[a] = 32'((64'sd1 <<< 30) / longint'($signed(r.d[a])));
    end
    return r;
  endfunction

  function automatic ray_t mk_ray(logic [15:0] c, logic [15:0] f,
                                  logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
    ray_t r;
    r.d = '{dx, dy, dz};
    for (int a = 0; a < 3; a++) begin
      r.oc[a] = c;
      r.of[a] = f;
      r.inv[a] = (r.d[a] == 0) ? 32'hFFFF_FFFF :
                 32'((64'sd1 <<< 30) / longint'($signed(r.d[a])));
    end
    return r;
  endfunction

  initial begin
    logic [12:0] ranges[6];
    ray_t r;
    ranges = '{13'd0, 13'd8191, 13'd256, 13'd5120, 13'd1280, 13'd640};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset range, then field extremes and corner cases.
    write_range(13'd1280);
    send_ray(mk_ray(16'd0, 16'd0, 16'd0, 16'd0, 16'd0));          // stays in origin cell
    send_ray(mk_ray(16'd0, 16'd0, 16'sd16384, 16'd0, 16'd0));     // +x
    send_ray(mk_ray(16'd0, 16'hFFFF, -16'sd16384, 16'd0, 16'd0)); // -x
    send_ray(mk_ray(16'd5, 16'h8000, 16'd0, 16'sd16384, 16'd0));  // +y
    send_ray(mk_ray(16'd5, 16'h0000, 16'd0, -16'sd16384, 16'd0)); // -y
    send_ray(mk_ray(16'd9, 16'h4000, 16'd0, 16'd0, 16'sd16384));  // +z
    send_ray(mk_ray(16'd9, 16'hC000, 16'd0, 16'd0, -16'sd16384)); // -z
    send_ray(mk_ray(16'h7FFE, 16'h8000, 16'sd9459, 16'sd9459, 16'sd9459)); // wrap at top
    send_ray(mk_ray(16'h8001, 16'h8000, -16'sd9459, -16'sd9459, -16'sd9459));
    send_ray(mk_ray(16'd0, 16'h8000, 16'sd11585, 16'sd11585, 16'd0)); // tie x/y
    send_ray(mk_ray(16'd0, 16'h8000, 16'd0, 16'sd11585, 16'sd11585)); // tie y/z
    r = mk_ray(16'd3, 16'd100, 16'sd16384, 16'd0, 16'd0);
    r.inv[0] = 32'd0;             // zero crossing interval: x is picked every step
    send_ray(r);
    r.inv[0] = 32'h7FFF_FFFF;     // huge interval: saturated times
    send_ray(r);
    r = mk_ray(16'd0, 16'd1, -16'sd1, 16'sd1, -16'sd1);
    r.inv = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001};
    send_ray(r);
    send_ray(mk_ray(16'h8000, 16'hFFFF, 16'sd1, -16'sd1, 16'sd16384));

    // Random phases over several range settings.
    for (int p = 0; p < 6; p++) begin
      write_range((p == 5) ? 13'($urandom) : ranges[p]);
      for (int i = 0; i < 70; i++) begin
        if (p == 1 && i == 10) hold_req = 1;
        if (p == 2 && i == 20) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (sb.cells_q.size() != 0) @(posedge clk);
        end
        if (p == 5 && i == 35) calm = 1;
        send_ray(rand_ray($urandom_range(0, 4) == 0));
      end
    end
    in_valid <= 1'b0;

    while (sb.cells_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("[voxel_ray_traversal] OK");
    else
      $display("[voxel_ray_traversal] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/vrt_pkg.sv
hdl/vrt_mul.sv
hdl/voxel_ray_traversal.sv
verif/tb.sv
